// ===== sv/rfbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Remote frame button classifier package
// Shared constants for the remote frame button classifier core.
// ----------------------------------------------------------------------------
package rfbc_pkg;

   localparam int FRAME_LENGTH = 8;
   localparam int NUM_BUTTONS  = 8;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int TIME_W   = 16;
   localparam int SERIAL_W = 24;
   localparam int CSR_W    = 24;
   localparam int RSP_W    = 48;

   localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0a;
   localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0d;

   localparam logic [COUNT_W-1:0] FRAME_FULL = COUNT_W'(FRAME_LENGTH);

   localparam logic [BYTE_W-1:0] BUTTON_MASK = BYTE_W'((1 << NUM_BUTTONS) - 1);

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic REG_SERIAL_NUMBER    = 1'b0;
   localparam logic REG_LONG_PRESS_TICKS = 1'b1;

   localparam logic [SERIAL_W-1:0] SERIAL_RESET = 24'd7649;
   localparam logic [TIME_W-1:0]   LONG_RESET   = 16'd10000;

endpackage

`default_nettype wire

// ===== sv/remote_frame_button_classifier_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Remote frame button classifier core
// Gathers radio UART bytes into frames, reports button changes with link
// bytes and short presses, and counts timer ticks to flag long presses.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tdata = rx_byte[7:0], tuser = command (1 = tick)
//  rsp_    | out       | tdata = buttons, tx_voltage, link_state,
//          |           |   signal_strength, short_presses, long_presses
//          |           | tuser = report_valid
//  csr_    | in        | index 0 = serial_number, 1 = long_press_ticks
//
// Each transfer is handled combinationally and its result, if any, is shown
// in the next cycle from the output register; one transfer is taken per cycle
// unless a result is stalled. The single output register sets the rate: a new
// transfer is taken while it is empty or its result is taken in the same cycle.
// Reset is synchronous and clears the frame count, button state and time.
// A stalled result holds its data and blocks only new transfers.
// ----------------------------------------------------------------------------
module remote_frame_button_classifier_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [7:0]                  req_tdata,  // rx_byte[7:0]
   input  wire logic                        req_tuser,  // command[0]
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   // buttons[7:0], tx_voltage[15:8], link_state[23:16],
   // signal_strength[31:24], short_presses[39:32], long_presses[47:40]
   output      logic [rfbc_pkg::RSP_W-1:0]  rsp_tdata,
   output      logic                        rsp_tuser,  // report_valid[0]
   input  wire logic                        csr_we,
   input  wire logic                        csr_addr,
   input  wire logic [rfbc_pkg::CSR_W-1:0]  csr_wdata
);

   typedef logic [rfbc_pkg::BYTE_W-1:0] byte_type;
   typedef logic [rfbc_pkg::TIME_W-1:0] time_type;

   logic [rfbc_pkg::SERIAL_W-1:0] serial_ff;
   time_type                      long_ff;

   logic [rfbc_pkg::COUNT_W-1:0]  count_ff, count_in;
   byte_type                      frame_ff [rfbc_pkg::FRAME_LENGTH];
   byte_type                      prev_ff, prev_in;
   byte_type                      held_ff, held_in;
   time_type                      start_ff [rfbc_pkg::NUM_BUTTONS];
   byte_type                      start_we;
   time_type                      time_ff, time_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rfbc_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   logic                          accept;
   logic                          store_byte;
   logic                          has_result;
   byte_type                      btn;
   byte_type                      rises;
   byte_type                      falls;
   byte_type                      shrt;
   byte_type                      lng;
   time_type                      elapsed [rfbc_pkg::NUM_BUTTONS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign btn   = frame_ff[3];
   assign rises = btn & ~prev_ff & rfbc_pkg::BUTTON_MASK;
   assign falls = prev_ff & ~btn & rfbc_pkg::BUTTON_MASK;
   assign shrt  = falls & held_ff;

   always_comb begin
      time_in = time_ff + time_type'(1);
      lng     = '0;
      for (int i = 0; i < rfbc_pkg::NUM_BUTTONS; i++) begin
         elapsed[i] = time_in - start_ff[i];
         lng[i]     = held_ff[i] && (elapsed[i] > long_ff);
      end
   end

   always_comb begin
      count_in    = count_ff;
      prev_in     = prev_ff;
      held_in     = held_ff;
      start_we    = '0;
      store_byte  = 1'b0;
      has_result  = 1'b0;
      rsp_data_in = '0;
      rsp_user_in = 1'b0;
      if (req_tuser == rfbc_pkg::CMD_TICK) begin
         held_in     = held_ff & ~lng;
         has_result  = (lng != '0);
         rsp_data_in = {lng, 40'd0};
      end else if (req_tdata == rfbc_pkg::BYTE_LF) begin
         count_in = count_ff;
      end else if (req_tdata == rfbc_pkg::BYTE_CR) begin
         count_in = '0;
         if (count_ff == rfbc_pkg::FRAME_FULL &&
             {frame_ff[2], frame_ff[1], frame_ff[0]} == serial_ff &&
             btn != prev_ff) begin
            start_we    = rises & ~held_ff;
            held_in     = (held_ff | rises) & ~shrt;
            prev_in     = btn;
            has_result  = 1'b1;
            rsp_user_in = 1'b1;
            rsp_data_in = {8'd0, shrt, frame_ff[7], frame_ff[6], frame_ff[5], btn};
         end
      end else if (count_ff >= rfbc_pkg::FRAME_FULL) begin
         count_in = '0;
      end else begin
         store_byte = 1'b1;
         count_in   = count_ff + rfbc_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = has_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff    <= rfbc_pkg::SERIAL_RESET;
         long_ff      <= rfbc_pkg::LONG_RESET;
         count_ff     <= '0;
         prev_ff      <= '0;
         held_ff      <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               rfbc_pkg::REG_SERIAL_NUMBER: begin
                  serial_ff <= csr_wdata;
               end
               rfbc_pkg::REG_LONG_PRESS_TICKS: begin
                  long_ff <= csr_wdata[rfbc_pkg::TIME_W-1:0];
               end
               default: begin
                  serial_ff <= serial_ff;
               end
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
            prev_ff  <= prev_in;
            held_ff  <= held_in;
            if (req_tuser == rfbc_pkg::CMD_TICK) begin
               time_ff <= time_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_byte) begin
         frame_ff[count_ff[2:0]] <= req_tdata;
      end
      for (int i = 0; i < rfbc_pkg::NUM_BUTTONS; i++) begin
         if (accept && start_we[i]) begin
            start_ff[i] <= time_ff;
         end
      end
      if (accept && has_result) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   a_report_no_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_data_ff[47:40] == 8'd0)
      else $error("frame report carries long presses");

   a_tick_only_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_user_ff |->
         rsp_data_ff[47:40] != 8'd0 && rsp_data_ff[39:0] == 40'd0)
      else $error("tick result malformed");

   a_short_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> (rsp_data_ff[39:32] & rsp_data_ff[7:0]) == 8'd0)
      else $error("short press on a button still pressed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rfbc_pkg::FRAME_FULL)
      else $error("frame byte count out of range");

   a_held_mask: assert property (@(posedge clock) disable iff (reset)
      (held_ff & ~rfbc_pkg::BUTTON_MASK) == 8'd0)
      else $error("held flag beyond button count");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote frame button classifier testbench
// Feeds radio bytes and timer ticks into the classifier core and checks every
// result transfer against a cycle-free model of the framing, button change,
// short-press and long-press logic, or the table for directed result rows.
// A short directed table is followed by random frame, tick and noise sequences
// under several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import rfbc_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 290;
   localparam int PRINT_LIMIT  = 100;

   typedef struct packed {
      logic       report;
      logic [7:0] buttons;
      logic [7:0] tx_voltage;
      logic [7:0] link_state;
      logic [7:0] signal_strength;
      logic [7:0] short_presses;
      logic [7:0] long_presses;
   } remote_result_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              cmd;
      logic [7:0]        data;
      remote_result_type typed;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = 8'h00;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                rsp_tuser;
   logic                csr_we = 1'b0;
   logic                csr_addr = 1'b0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   logic [SERIAL_W-1:0] cfg_serial;
   logic [TIME_W-1:0]   cfg_hold_limit;
   logic [COUNT_W-1:0]  frame_count;
   logic [7:0]          frame_buf [FRAME_LENGTH];
   logic [7:0]          model_buttons;
   logic [7:0]          held_mask;
   logic [TIME_W-1:0]   press_time [NUM_BUTTONS];
   logic [TIME_W-1:0]   tick_time;

   remote_result_type   expected_events [$];
   int                  mismatch_count = 0;
   int                  items_sent = 0;
   int                  cycle_count = 0;
   int                  sender_idle_pct = 36;
   int                  receiver_idle_pct = 80;

   string field_names [7] = '{"report_valid", "buttons", "tx_voltage", "link_state",
                              "signal_strength", "short_presses", "long_presses"};

   directed_row_type directed_rows [24] = '{
      '{ROW_NONE,    CMD_TICK, 8'ha5,               '0},
      '{ROW_NONE,    CMD_BYTE, BYTE_CR,             '0},
      '{ROW_PREDICT, CMD_BYTE, SERIAL_RESET[7:0],   '0},
      '{ROW_PREDICT, CMD_BYTE, SERIAL_RESET[15:8],  '0},
      '{ROW_NONE,    CMD_BYTE, BYTE_LF,             '0},
      '{ROW_PREDICT, CMD_BYTE, SERIAL_RESET[23:16], '0},
      '{ROW_PREDICT, CMD_BYTE, 8'hff,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'h00,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'h00,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'h00,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'h00,               '0},
      '{ROW_RESULT,  CMD_BYTE, BYTE_CR,
        '{1'b1, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{ROW_NONE,    CMD_TICK, 8'h5a,               '0},
      '{ROW_PREDICT, CMD_BYTE, SERIAL_RESET[7:0],   '0},
      '{ROW_PREDICT, CMD_BYTE, SERIAL_RESET[15:8],  '0},
      '{ROW_PREDICT, CMD_BYTE, SERIAL_RESET[23:16], '0},
      '{ROW_PREDICT, CMD_BYTE, 8'h00,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'hff,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'hff,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'hff,               '0},
      '{ROW_PREDICT, CMD_BYTE, 8'hff,               '0},
      '{ROW_RESULT,  CMD_BYTE, BYTE_CR,
        '{1'b1, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00}},
      '{ROW_PREDICT, CMD_BYTE, 8'h80,               '0},
      '{ROW_NONE,    CMD_BYTE, BYTE_CR,             '0}
   };

   remote_frame_button_classifier_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("error at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endtask

   function automatic bit classify_item(input logic cmd, input logic [7:0] rx,
                                        output remote_result_type res);
      logic             full;
      logic [7:0]       btn;
      logic [TIME_W-1:0] elapsed;
      res = '0;
      if (cmd == CMD_TICK) begin
         tick_time = tick_time + 1'b1;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (held_mask[i] && BUTTON_MASK[i]) begin
               elapsed = tick_time - press_time[i];
               if (elapsed > cfg_hold_limit) begin
                  res.long_presses[i] = 1'b1;
                  held_mask[i] = 1'b0;
               end
            end
         end
         return res.long_presses != 8'h00;
      end
      if (rx == BYTE_LF) return 1'b0;
      if (rx != BYTE_CR) begin
         if (frame_count >= FRAME_FULL) begin
            frame_count = '0;
         end else begin
            frame_buf[frame_count[2:0]] = rx;
            frame_count = frame_count + 1'b1;
         end
         return 1'b0;
      end
      full = (frame_count == FRAME_FULL);
      frame_count = '0;
      if (!full) return 1'b0;
      if ({frame_buf[2], frame_buf[1], frame_buf[0]} != cfg_serial) return 1'b0;
      btn = frame_buf[3];
      if (btn == model_buttons) return 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (BUTTON_MASK[i]) begin
            if (btn[i] && !model_buttons[i]) begin
               if (!held_mask[i]) begin
                  held_mask[i] = 1'b1;
                  press_time[i] = tick_time;
               end
            end else if (model_buttons[i] && !btn[i] && held_mask[i]) begin
               res.short_presses[i] = 1'b1;
               held_mask[i] = 1'b0;
            end
         end
      end
      model_buttons = btn;
      res.report = 1'b1;
      res.buttons = btn;
      res.tx_voltage = frame_buf[5];
      res.link_state = frame_buf[6];
      res.signal_strength = frame_buf[7];
      return 1'b1;
   endfunction

   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == BYTE_LF || b == BYTE_CR);
      return b;
   endfunction

   function automatic logic [SERIAL_W-1:0] random_serial();
      return {payload_byte(), payload_byte(), payload_byte()};
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] data,
                            input row_kind_type kind = ROW_PREDICT,
                            input remote_result_type typed = '0);
      remote_result_type outcome;
      bit                produced;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      produced = classify_item(cmd, data, outcome);
      case (kind)
         ROW_PREDICT: begin
            if (produced) expected_events.push_back(outcome);
         end
         ROW_RESULT: begin
            expected_events.push_back(typed);
         end
         default: begin
         end
      endcase
      if (!(cmd == CMD_BYTE && data == BYTE_LF)) items_sent++;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   task automatic program_settings(input logic [SERIAL_W-1:0] serial,
                                   input logic [TIME_W-1:0] hold_limit);
      csr_we    <= 1'b1;
      csr_addr  <= REG_SERIAL_NUMBER;
      csr_wdata <= CSR_W'(serial);
      @(posedge clock);
      cfg_serial = serial;
      csr_addr  <= REG_LONG_PRESS_TICKS;
      csr_wdata <= CSR_W'(hold_limit);
      @(posedge clock);
      cfg_hold_limit = hold_limit;
      csr_we <= 1'b0;
   endtask

   task automatic random_sequence();
      int         pick;
      int         lf_at;
      int         k;
      logic [7:0] body [FRAME_LENGTH];
      logic [7:0] btn;
      pick = $urandom_range(99);
      if (pick < 25) begin
         repeat (($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6))
            send_item(CMD_TICK, 8'($urandom));
      end else if (pick < 30) begin
         repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
      end else if (pick < 36) begin
         repeat ($urandom_range(0, FRAME_LENGTH - 1)) send_item(CMD_BYTE, payload_byte());
         send_item(CMD_BYTE, BYTE_CR);
      end else begin
         case ($urandom_range(9))
            0: btn = model_buttons;
            1: btn = model_buttons ^ 8'(1 << $urandom_range(7));
            2: btn = 8'h00;
            3: btn = 8'hff;
            4: btn = ~model_buttons;
            default: btn = 8'($urandom);
         endcase
         if (btn == BYTE_LF || btn == BYTE_CR) btn = btn ^ 8'h40;
         body[0] = cfg_serial[7:0];
         body[1] = cfg_serial[15:8];
         body[2] = cfg_serial[23:16];
         body[3] = btn;
         for (int i = 4; i < FRAME_LENGTH; i++) body[i] = payload_byte();
         if (pick < 42) begin
            k = $urandom_range(2);
            body[k] = body[k] ^ 8'(1 << $urandom_range(7));
         end
         lf_at = ($urandom_range(5) == 0) ? $urandom_range(FRAME_LENGTH) : FRAME_LENGTH + 1;
         for (int i = 0; i < FRAME_LENGTH; i++) begin
            if (i == lf_at) send_item(CMD_BYTE, BYTE_LF);
            send_item(CMD_BYTE, body[i]);
         end
         if (lf_at == FRAME_LENGTH) send_item(CMD_BYTE, BYTE_LF);
         if (pick < 47) repeat ($urandom_range(1, 4)) send_item(CMD_BYTE, payload_byte());
         send_item(CMD_BYTE, BYTE_CR);
      end
   endtask

   always @(posedge clock) begin
      remote_result_type want;
      logic [7:0]        got_f [7];
      logic [7:0]        want_f [7];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("result transfer with no result expected");
         end else begin
            want = expected_events.pop_front();
            got_f = '{8'(rsp_tuser), rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                      rsp_tdata[31:24], rsp_tdata[39:32], rsp_tdata[47:40]};
            want_f = '{8'(want.report), want.buttons, want.tx_voltage, want.link_state,
                       want.signal_strength, want.short_presses, want.long_presses};
            for (int f = 0; f < 7; f++) begin
               if (got_f[f] !== want_f[f]) begin
                  report_mismatch($sformatf("%s is %02h, expected %02h",
                                            field_names[f], got_f[f], want_f[f]));
               end
            end
         end
      end
   end

   initial begin
      int phase_start;
      cfg_serial     = SERIAL_RESET;
      cfg_hold_limit = LONG_RESET;
      frame_count    = '0;
      model_buttons  = 8'h00;
      held_mask      = 8'h00;
      tick_time      = '0;
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      foreach (press_time[i]) press_time[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].cmd, directed_rows[r].data,
                   directed_rows[r].kind, directed_rows[r].typed);
      end

      for (int p = 0; p < 6; p++) begin
         pause_until_drained();
         repeat (4) @(posedge clock);
         case (p)
            0: program_settings(24'h000000, 16'd0);
            1: program_settings(random_serial(), 16'($urandom_range(2, 30)));
            2: program_settings(24'hffffff, 16'hffff);
            3: program_settings(random_serial(), 16'($urandom_range(1, 8)));
            4: program_settings(random_serial(), 16'($urandom_range(2, 30)));
            default: program_settings(random_serial(), 16'd100);
         endcase
         if (p == 2) begin
            sender_idle_pct   = 80;
            receiver_idle_pct = 36;
         end else if (p == 4) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(199) == 0) pause_until_drained();
            random_sequence();
         end
      end

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rfbc_pkg.sv
sv/remote_frame_button_classifier_core.sv
verif/tb_top.sv
